### sv/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared constants, types and the 5x7 font table for the glyph row renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int CHARS_PER_LINE = 77;
  localparam int FRAME_WIDTH    = 800;
  localparam int FRAME_HEIGHT   = 480;
  localparam int GLYPH_GAP      = 4;
  localparam int LINE_GAP       = 1;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int LINE_ROWS   = GLYPH_ROWS + LINE_GAP;
  localparam int GLYPH_PITCH = GLYPH_COLS + GLYPH_GAP;
  localparam int FIRST_CODE  = 32;
  localparam int LAST_CODE   = 122;
  localparam int NUM_GLYPHS  = LAST_CODE - FIRST_CODE + 1;
  localparam int LINE_BYTES  = 4 * FRAME_WIDTH;

  localparam int CODE_W  = 8;
  localparam int GLYPH_W = 7;
  localparam int COL_W   = 7;
  localparam int ROW_W   = $clog2(FRAME_HEIGHT);
  localparam int STEP_W  = 4;
  localparam int ROWY_W  = 9;
  localparam int X_W     = 10;
  localparam int MASK_W  = 5;
  localparam int ADDR_W  = 21;
  localparam int FLIP_W  = ROW_W + 1;
  localparam int CALC_W  = $clog2(LINE_BYTES) + FLIP_W + 2;
  localparam int COLOR_W = 32;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 48;

  localparam logic [COLOR_W-1:0] BRUSH_RESET = 32'hFFFF_C125;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_GLYPH = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_FIRST,
    BK_CLEAR,
    BK_GLYPH
  } bk_state_t;

  // one classified character, queued between front and back
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               line_start;
    logic [X_W-1:0]     x_start;
    logic [ROW_W-1:0]   top;
  } desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  localparam logic [7:0] FONT [NUM_GLYPHS][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h2f,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'hc4,8'hc8,8'h10,8'h26,8'h46},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h08,8'h08,8'h3e,8'h08,8'h08},
    '{8'h00,8'h00,8'h50,8'h30,8'h00}, '{8'h10,8'h10,8'h10,8'h10,8'h10},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
    '{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h59,8'h51,8'h3e},
    '{8'h7e,8'h11,8'h11,8'h11,8'h7e}, '{8'h7f,8'h49,8'h49,8'h49,8'h36},
    '{8'h3e,8'h41,8'h41,8'h41,8'h22}, '{8'h7f,8'h41,8'h41,8'h22,8'h1c},
    '{8'h7f,8'h49,8'h49,8'h49,8'h41}, '{8'h7f,8'h09,8'h09,8'h09,8'h01},
    '{8'h3e,8'h41,8'h49,8'h49,8'h7a}, '{8'h7f,8'h08,8'h08,8'h08,8'h7f},
    '{8'h00,8'h41,8'h7f,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3f,8'h01},
    '{8'h7f,8'h08,8'h14,8'h22,8'h41}, '{8'h7f,8'h40,8'h40,8'h40,8'h40},
    '{8'h7f,8'h02,8'h0c,8'h02,8'h7f}, '{8'h7f,8'h04,8'h08,8'h10,8'h7f},
    '{8'h3e,8'h41,8'h41,8'h41,8'h3e}, '{8'h7f,8'h09,8'h09,8'h09,8'h06},
    '{8'h3e,8'h41,8'h51,8'h21,8'h5e}, '{8'h7f,8'h09,8'h19,8'h29,8'h46},
    '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7f,8'h01,8'h01},
    '{8'h3f,8'h40,8'h40,8'h40,8'h3f}, '{8'h1f,8'h20,8'h40,8'h20,8'h1f},
    '{8'h3f,8'h40,8'h38,8'h40,8'h3f}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
    '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
    '{8'h00,8'h7f,8'h41,8'h41,8'h00}, '{8'h55,8'h2a,8'h55,8'h2a,8'h55},
    '{8'h00,8'h41,8'h41,8'h7f,8'h00}, '{8'h04,8'h02,8'h01,8'h02,8'h04},
    '{8'h40,8'h40,8'h40,8'h40,8'h40}, '{8'h00,8'h01,8'h02,8'h04,8'h00},
    '{8'h20,8'h54,8'h54,8'h54,8'h78}, '{8'h7f,8'h48,8'h44,8'h44,8'h38},
    '{8'h38,8'h44,8'h44,8'h44,8'h20}, '{8'h38,8'h44,8'h44,8'h48,8'h7f},
    '{8'h38,8'h54,8'h54,8'h54,8'h18}, '{8'h08,8'h7e,8'h09,8'h01,8'h02},
    '{8'h0c,8'h52,8'h52,8'h52,8'h3e}, '{8'h7f,8'h08,8'h04,8'h04,8'h78},
    '{8'h00,8'h44,8'h7d,8'h40,8'h00}, '{8'h20,8'h40,8'h44,8'h3d,8'h00},
    '{8'h7f,8'h10,8'h28,8'h44,8'h00}, '{8'h00,8'h41,8'h7f,8'h40,8'h00},
    '{8'h7c,8'h04,8'h18,8'h04,8'h78}, '{8'h7c,8'h08,8'h04,8'h04,8'h78},
    '{8'h38,8'h44,8'h44,8'h44,8'h38}, '{8'h7c,8'h14,8'h14,8'h14,8'h08},
    '{8'h08,8'h14,8'h14,8'h18,8'h7c}, '{8'h7c,8'h08,8'h04,8'h04,8'h08},
    '{8'h48,8'h54,8'h54,8'h54,8'h20}, '{8'h04,8'h3f,8'h44,8'h40,8'h20},
    '{8'h3c,8'h40,8'h40,8'h20,8'h7c}, '{8'h1c,8'h20,8'h40,8'h20,8'h1c},
    '{8'h3c,8'h40,8'h30,8'h40,8'h3c}, '{8'h44,8'h28,8'h10,8'h28,8'h44},
    '{8'h0c,8'h50,8'h50,8'h50,8'h3c}, '{8'h44,8'h64,8'h54,8'h4c,8'h44}
  };

  // pixel mask of one font row: font bytes are columns, bit r is row r
  function automatic logic [MASK_W-1:0] glyph_mask(input logic [GLYPH_W-1:0] g,
                                                   input logic [2:0] r);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      m[c] = FONT[g][c][r];
    end
    return m;
  endfunction

endpackage

### sv/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front
// Accepts characters, maps them to font indexes and tracks column and line top.
// ----------------------------------------------------------------------------
module tgr_front import tgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CODE_W-1:0] char_code,
  input  logic              end_of_text,
  output desc_t             desc
);

  logic [COL_W-1:0] char_column;
  logic [COL_W-1:0] char_column_next;
  logic [ROW_W-1:0] line_top_row;
  logic [ROW_W-1:0] line_top_row_next;

  logic [COL_W-1:0]   col_inc;
  logic [ROW_W:0]     top_sum;
  logic [X_W+1:0]     x_calc;
  logic               in_font;

  assign in_font = (char_code >= CODE_W'(FIRST_CODE)) && (char_code <= CODE_W'(LAST_CODE));
  assign x_calc  = (X_W+2)'(char_column) * (X_W+2)'(GLYPH_PITCH) + (X_W+2)'(1);

  always_comb begin
    desc.glyph      = in_font ? GLYPH_W'(char_code - CODE_W'(FIRST_CODE)) : '0;
    desc.line_start = (char_column == '0);
    desc.x_start    = x_calc[X_W-1:0];
    desc.top        = line_top_row;
  end

  assign col_inc = char_column + COL_W'(1);
  assign top_sum = (ROW_W+1)'(line_top_row) + (ROW_W+1)'(LINE_ROWS);

  always_comb begin
    char_column_next  = col_inc;
    line_top_row_next = line_top_row;
    if (end_of_text || (col_inc >= COL_W'(CHARS_PER_LINE))) begin
      char_column_next  = '0;
      line_top_row_next = (top_sum >= (ROW_W+1)'(FRAME_HEIGHT))
                          ? ROW_W'(top_sum - (ROW_W+1)'(FRAME_HEIGHT))
                          : ROW_W'(top_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_column  <= '0;
      line_top_row <= '0;
    end else if (accept) begin
      char_column  <= char_column_next;
      line_top_row <= line_top_row_next;
    end
  end

endmodule

### sv/tgr_queue.sv
// ----------------------------------------------------------------------------
// tgr_queue
// Two-entry descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module tgr_queue import tgr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  desc_t   push_data,
  input  logic    pop,
  output desc_t   head,
  output q_stat_t stat
);

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back
// Sequences row clears and glyph rows for the head descriptor into the
// output register, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tgr_back import tgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  desc_t                  head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  logic              fire;
  cmd_kind_t         kind;
  logic [STEP_W-1:0] offset;
  logic              beat_last;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  row;
  logic [FLIP_W-1:0] flipped;
  logic [CALC_W-1:0] addr_calc;
  logic [X_W-1:0]    x_beat;
  logic [MASK_W-1:0] mask_beat;

  assign fire = head_valid && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    pop        = 1'b0;
    case (state)
      BK_FIRST: begin
        step_next  = STEP_W'(1);
        state_next = head.line_start ? BK_CLEAR : BK_GLYPH;
      end
      BK_CLEAR: begin
        if (step == STEP_W'(LINE_ROWS - 1)) begin
          state_next = BK_GLYPH;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      BK_GLYPH: begin
        if (step == STEP_W'(GLYPH_ROWS - 1)) begin
          state_next = BK_FIRST;
          step_next  = '0;
          pop        = fire;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      default: begin
        state_next = BK_FIRST;
        step_next  = '0;
      end
    endcase
  end

  // beat contents
  always_comb begin
    kind      = CMD_GLYPH;
    offset    = step;
    beat_last = 1'b0;
    case (state)
      BK_FIRST: begin
        kind   = head.line_start ? CMD_CLEAR : CMD_GLYPH;
        offset = head.line_start ? STEP_W'(1) : '0;
      end
      BK_CLEAR: begin
        kind   = CMD_CLEAR;
        offset = step + STEP_W'(1);
      end
      BK_GLYPH: begin
        beat_last = (step == STEP_W'(GLYPH_ROWS - 1));
      end
      default: begin
        kind = CMD_GLYPH;
      end
    endcase
  end

  assign row_sum   = (ROW_W+1)'(head.top) + (ROW_W+1)'(offset);
  assign row       = (row_sum >= (ROW_W+1)'(FRAME_HEIGHT))
                     ? ROW_W'(row_sum - (ROW_W+1)'(FRAME_HEIGHT)) : ROW_W'(row_sum);
  assign x_beat    = (kind == CMD_GLYPH) ? head.x_start : '0;
  assign mask_beat = (kind == CMD_GLYPH) ? glyph_mask(head.glyph, offset[2:0]) : '0;
  assign flipped   = FLIP_W'(FRAME_HEIGHT - 1) - FLIP_W'(row);
  assign addr_calc = CALC_W'(LINE_BYTES) * CALC_W'(flipped)
                   + CALC_W'({x_beat, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_FIRST;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        state <= state_next;
        step  <= step_next;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, addr_calc[ADDR_W-1:0], mask_beat, x_beat, ROWY_W'(row)};
      m_tuser <= kind;
      m_tlast <= beat_last;
    end
  end

endmodule

### sv/text_glyph_row_renderer.sv
// ----------------------------------------------------------------------------
// text_glyph_row_renderer
// Renders text characters through a 5x7 font into framebuffer row commands.
// ----------------------------------------------------------------------------
// The first beat of a character passes the queue, then the output register.
// Throughput: one output beat per cycle unless m_tready stalls; a character
// gives 7 glyph row beats, after 8 row clears when it opens a line.
// A two-entry queue lets the next character be accepted while one renders.
// Reset (rst, synchronous): column and line top to 0, queue and output empty,
// brush color to 0xFFFFC125.
module text_glyph_row_renderer import tgr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic                   s_tlast,   // end_of_text
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [8:0] row_y, [18:9] x_start, [23:19] pixel_mask, [44:24] byte_address
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tuser,   // cmd_kind
  output logic                   m_tlast,   // last
  input  logic                   brush_color_we,
  input  logic [COLOR_W-1:0]     brush_color_wdata
);

  logic [COLOR_W-1:0] brush_color;
  logic               accept;
  logic               pop;
  desc_t              desc;
  desc_t              head;
  q_stat_t            q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_color <= BRUSH_RESET;
    end else if (brush_color_we) begin
      brush_color <= brush_color_wdata;
    end
  end

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  tgr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (s_tdata[CODE_W-1:0]),
    .end_of_text (s_tlast),
    .desc        (desc)
  );

  tgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  tgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_stat.valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_clear_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == CMD_CLEAR)) |-> ((m_tdata[23:9] == '0) && !m_tlast))
    else $error("row clear beat carries glyph fields or last");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] < 9'(FRAME_HEIGHT)) || (FRAME_HEIGHT > 512))
    else $error("row outside frame");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (m_tvalid && m_tlast && (m_tuser == CMD_GLYPH)))
    else $error("descriptor retired without final glyph beat");

  a_stall_queue: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_stat.valid)
    else $error("input stalled with empty queue");

  a_brush_write: assert property (@(posedge clk) disable iff (rst)
    ($past(brush_color_we) && !$past(rst)) |-> (brush_color == $past(brush_color_wdata)))
    else $error("brush color write lost");

endmodule
